// ===== src/fdha_pkg.sv =====
// Shared types and constants for the fenced descriptor heap allocator.
package fdha_pkg;

    localparam int MAX_HEAPS_DEF    = 16;
    localparam int RETIRE_DEPTH_DEF = 32;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE  = 3'd1;
    localparam logic [2:0] ST_NO_HEAP    = 3'd2;
    localparam logic [2:0] ST_QUEUE_FULL = 3'd3;
    localparam logic [2:0] ST_IGNORED    = 3'd4;

    localparam logic CFG_HEAP_SIZE   = 1'b0;
    localparam logic CFG_SLOT_STRIDE = 1'b1;

    localparam logic [20:0] REF_MAX = 21'h1FFFFF;

    // One request as it passes from the front end to the execution engine.
    typedef struct packed {
        logic        action;
        logic [19:0] count;
        logic [4:0]  heap_id;
        logic [63:0] target_fence;
        logic [63:0] completed_fence;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  block_heap;
        logic [19:0] slot_offset;
        logic [29:0] byte_offset;
        logic        deferred;
        logic        opened_heap;
    } rsp_t;

endpackage

// ===== src/fdha_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module fdha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/fdha_front.sv =====
// Front end: accepts requests and holds them in a two-entry queue.
module fdha_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  fdha_pkg::req_t  in_req,
    output logic            q_valid,
    input  logic            q_ready,
    output fdha_pkg::req_t  q_req
);
    fdha_pkg::req_t buf_reg [2];
    logic       wp_reg, rp_reg, wp_next, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = buf_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            buf_reg[wp_reg] <= in_req;
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_full_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 && !pop |=> cnt_reg == 2'd2) else $error("overfill");
    a_empty_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd0 && !push |=> cnt_reg == 2'd0) else $error("underflow");
endmodule

// ===== src/fdha_back.sv =====
// Back end: executes allocate and free requests with sequential scans.
module fdha_back #(
    parameter int MAX_HEAPS    = fdha_pkg::MAX_HEAPS_DEF,
    parameter int RETIRE_DEPTH = fdha_pkg::RETIRE_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [19:0]     heap_size,
    input  logic [10:0]     slot_stride,
    input  logic            q_valid,
    output logic            q_ready,
    input  fdha_pkg::req_t  q_req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output fdha_pkg::rsp_t  rsp
);
    localparam int HW = (MAX_HEAPS > 1) ? $clog2(MAX_HEAPS) : 1;
    localparam int RW = (RETIRE_DEPTH > 1) ? $clog2(RETIRE_DEPTH) : 1;
    localparam int OW = $clog2(MAX_HEAPS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FREE  = 4'd1;
    localparam logic [3:0] S_RSCAN = 4'd2;
    localparam logic [3:0] S_RREAD = 4'd3;
    localparam logic [3:0] S_RDO   = 4'd4;
    localparam logic [3:0] S_HSCAN = 4'd5;
    localparam logic [3:0] S_ISSUE = 4'd6;
    localparam logic [3:0] S_MUL   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]  state_reg, state_next;
    fdha_pkg::req_t req_reg, req_next;
    logic [20:0] ref_reg [MAX_HEAPS];
    logic [OW-1:0] opened_reg, opened_next;
    logic [HW-1:0] cur_reg, cur_next;
    logic        cur_valid_reg, cur_valid_next;
    logic [19:0] off_reg, off_next;
    logic [RETIRE_DEPTH-1:0] used_reg, used_next;
    logic [RW:0] idx_reg, idx_next;
    logic        found_reg, found_next;
    logic [HW-1:0] pick_reg, pick_next;
    fdha_pkg::rsp_t rsp_reg, rsp_next;
    logic        rsp_valid_reg, rsp_valid_next;
    logic [29:0] prod_reg, prod_next;

    logic        ref_inc, ref_dec;
    logic [HW-1:0] ref_idx;
    logic        ram_we;
    logic [RW-1:0] ram_waddr, ram_raddr;
    logic [HW+63:0] ram_wdata, ram_rdata;

    logic [RW-1:0] free_slot;
    logic          free_any;
    logic [4:0]    hraw;
    logic          hraw_ok;
    logic [20:0]   hraw_ref;
    logic [RW-1:0] idx_lo;

    assign hraw   = req_reg.heap_id;
    assign idx_lo = idx_reg[RW-1:0];
    assign hraw_ref = ref_reg[hraw[HW-1:0]];
    assign hraw_ok = !hraw[4] && ({{(OW+1){1'b0}}, hraw} < {{6{1'b0}}, opened_reg})
                     && ({27'd0, hraw} < 32'(MAX_HEAPS)) && (hraw_ref != 21'd0);

    always_comb begin
        free_any  = 1'b0;
        free_slot = '0;
        for (int i = RETIRE_DEPTH - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_any  = 1'b1;
                free_slot = RW'(i);
            end
        end
    end

    fdha_ram #(.WIDTH(HW + 64), .DEPTH(RETIRE_DEPTH)) u_retire (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    assign q_ready   = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        opened_next    = opened_reg;
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        off_next       = off_reg;
        used_next      = used_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        pick_next      = pick_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        prod_next      = prod_reg;
        ref_inc        = 1'b0;
        ref_dec        = 1'b0;
        ref_idx        = '0;
        ram_we         = 1'b0;
        ram_waddr      = free_slot;
        ram_wdata      = {req_reg.heap_id[HW-1:0], req_reg.target_fence};
        ram_raddr      = idx_lo;
        unique case (state_reg)
            S_IDLE: begin
                if (q_valid && q_ready) begin
                    req_next   = q_req;
                    rsp_next   = '0;
                    state_next = q_req.action ? S_FREE : S_RSCAN;
                    if (!q_req.action) begin
                        if (q_req.count > heap_size) begin
                            rsp_next.status = fdha_pkg::ST_TOO_LARGE;
                            state_next      = S_OUT;
                        end else if (cur_valid_reg &&
                                     {1'b0, off_reg} + {1'b0, q_req.count}
                                     <= {1'b0, heap_size}) begin
                            state_next = S_ISSUE;
                        end
                    end
                    idx_next = '0;
                end
            end
            S_FREE: begin
                state_next = S_OUT;
                if (!hraw_ok) begin
                    rsp_next.status = fdha_pkg::ST_IGNORED;
                end else if (req_reg.completed_fence >= req_reg.target_fence) begin
                    ref_dec = 1'b1;
                    ref_idx = hraw[HW-1:0];
                end else if (free_any) begin
                    ram_we = 1'b1;
                    used_next[free_slot] = 1'b1;
                    rsp_next.deferred = 1'b1;
                end else begin
                    rsp_next.status = fdha_pkg::ST_QUEUE_FULL;
                end
            end
            S_RSCAN: begin
                // walk retire entries; read only the used ones
                if (idx_reg == (RW+1)'(RETIRE_DEPTH)) begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = S_HSCAN;
                end else if (used_reg[idx_lo]) begin
                    state_next = S_RREAD;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_RREAD: begin
                state_next = S_RDO;
            end
            S_RDO: begin
                if (req_reg.completed_fence >= ram_rdata[63:0]) begin
                    ref_dec = 1'b1;
                    ref_idx = ram_rdata[HW+63:64];
                    used_next[idx_lo] = 1'b0;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_RSCAN;
            end
            S_HSCAN: begin
                if (32'(idx_reg) >= 32'(MAX_HEAPS) ||
                    32'(idx_reg) >= 32'(opened_reg)) begin
                    state_next = S_ISSUE;
                    if (found_reg) begin
                        cur_next = pick_reg;
                    end else if (opened_reg >= OW'(MAX_HEAPS)) begin
                        rsp_next.status = fdha_pkg::ST_NO_HEAP;
                        state_next      = S_OUT;
                    end else begin
                        cur_next    = opened_reg[HW-1:0];
                        opened_next = opened_reg + 1'b1;
                        rsp_next.opened_heap = 1'b1;
                    end
                    if (state_next == S_ISSUE) begin
                        cur_valid_next = 1'b1;
                        off_next       = '0;
                    end
                end else begin
                    if (ref_reg[idx_reg[HW-1:0]] == 21'd0) begin
                        found_next = 1'b1;
                        pick_next  = idx_reg[HW-1:0];
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_ISSUE: begin
                rsp_next.block_heap  = 4'(cur_reg);
                rsp_next.slot_offset = off_reg;
                prod_next  = 30'({11'd0, off_reg} * {20'd0, slot_stride});
                ref_inc    = 1'b1;
                ref_idx    = cur_reg;
                off_next   = off_reg + req_reg.count;
                state_next = S_MUL;
            end
            S_MUL: begin
                rsp_next.byte_offset = prod_reg;
                state_next           = S_OUT;
            end
            S_OUT: begin
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            opened_reg    <= '0;
            cur_valid_reg <= 1'b0;
            off_reg       <= '0;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_HEAPS; i++) begin
                ref_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            opened_reg    <= opened_next;
            cur_valid_reg <= cur_valid_next;
            off_reg       <= off_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
            if (ref_inc && ref_reg[ref_idx] != fdha_pkg::REF_MAX) begin
                ref_reg[ref_idx] <= ref_reg[ref_idx] + 1'b1;
            end else if (ref_dec && ref_reg[ref_idx] != 21'd0) begin
                ref_reg[ref_idx] <= ref_reg[ref_idx] - 1'b1;
            end
        end
        req_reg   <= req_next;
        cur_reg   <= cur_next;
        idx_reg   <= idx_next;
        found_reg <= found_next;
        pick_reg  <= pick_next;
        rsp_reg   <= rsp_next;
        prod_reg  <= prod_next;
    end

    a_opened_max: assert property (@(posedge aclk) disable iff (!aresetn)
        opened_reg <= OW'(MAX_HEAPS)) else $error("too many heaps opened");
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp_valid_reg && !rsp_ready |=> rsp_valid_reg && $stable(rsp_reg))
        else $error("result dropped");
    a_issue_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MUL |-> cur_valid_reg) else $error("issue without heap");
endmodule

// ===== src/fenced_descriptor_heap_allocator_top.sv =====
// Top level of the fenced descriptor heap allocator.
// Usage:
//   Input channel s_*: one transfer per request (allocate a run or free a block),
//   carrying the completed fence value with every request.
//   Result channel m_*: exactly one transfer per request, in request order.
//   Config port: cfg_we/cfg_index/cfg_data write heap_size (0) or slot_stride (1);
//   write only while the block is idle.
// Sequencing: a free is decided in the free state and then output; an allocate
//   larger than heap_size goes straight to output; one that fits the current heap
//   goes to issue, multiply and output; one that switches heaps first walks the retire
//   queue (reading each queued entry) and then the opened heaps. The back end works
//   on one request at a time; these scans set the throughput.
// A two-entry queue in the front end keeps accepting transfers while the back
//   end works or while a result waits on m_ready.
// Reset (aresetn low, synchronous): drop all queued requests, clear reference
//   counts, opened heaps, the current heap and the retire queue; registers
//   return to heap_size 1024, slot_stride 32.
// When the receiver stalls, hold the result; the queue fills, then s_ready falls.
module fenced_descriptor_heap_allocator_top #(
    parameter int MAX_HEAPS    = fdha_pkg::MAX_HEAPS_DEF,
    parameter int RETIRE_DEPTH = fdha_pkg::RETIRE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [19:0] s_count,
    input  logic signed [4:0] s_heap_id,
    input  logic [63:0] s_target_fence,
    input  logic [63:0] s_completed_fence,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [3:0]  m_block_heap,
    output logic [19:0] m_slot_offset,
    output logic [29:0] m_byte_offset,
    output logic        m_deferred,
    output logic        m_opened_heap
);
    logic [19:0] heap_size_reg;
    logic [10:0] slot_stride_reg;
    fdha_pkg::req_t in_req, q_req;
    fdha_pkg::rsp_t rsp;
    logic q_valid, q_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_size_reg   <= 20'd1024;
            slot_stride_reg <= 11'd32;
        end else if (cfg_we) begin
            if (cfg_index == fdha_pkg::CFG_HEAP_SIZE) begin
                heap_size_reg <= cfg_data;
            end else begin
                slot_stride_reg <= cfg_data[10:0];
            end
        end
    end

    assign in_req = '{action: s_action, count: s_count, heap_id: s_heap_id,
                      target_fence: s_target_fence,
                      completed_fence: s_completed_fence};

    fdha_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_valid), .in_ready(s_ready),
        .in_req(in_req), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    fdha_back #(.MAX_HEAPS(MAX_HEAPS), .RETIRE_DEPTH(RETIRE_DEPTH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .heap_size(heap_size_reg),
        .slot_stride(slot_stride_reg), .q_valid(q_valid), .q_ready(q_ready),
        .q_req(q_req), .rsp_valid(m_valid), .rsp_ready(m_ready), .rsp(rsp)
    );

    assign m_status      = rsp.status;
    assign m_block_heap  = rsp.block_heap;
    assign m_slot_offset = rsp.slot_offset;
    assign m_byte_offset = rsp.byte_offset;
    assign m_deferred    = rsp.deferred;
    assign m_opened_heap = rsp.opened_heap;

    a_ok_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != fdha_pkg::ST_OK |-> !m_opened_heap && !m_deferred)
        else $error("failure with side flags");
    a_defer_free: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_deferred |-> m_block_heap == 4'd0 && m_slot_offset == 20'd0)
        else $error("free carries allocation fields");
    a_cfg_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_we |=> $stable(heap_size_reg) && $stable(slot_stride_reg))
        else $error("config changed without write");
endmodule
